// ----- rtl/core/ipv4hc_pkg.sv -----
// Shared constants, codes and types of the IPv4 header checker.
package ipv4hc_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned ADDR_W     = 32;
   localparam int unsigned COUNT_W    = 16;
   localparam int unsigned IHL_W      = 6;
   localparam int unsigned SUM_W      = 17;
   localparam int unsigned WORD_W     = 16;
   localparam int unsigned STATUS_W   = 3;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned RSP_DATA_W = 104;

   // IHL counts 32-bit words
   localparam int unsigned IHL_SHIFT = 2;

   localparam logic [IHL_W-1:0]  MIN_HEADER_BYTES = IHL_W'(20);
   localparam logic [WORD_W-1:0] GOOD_CHECKSUM    = 16'h0000;
   localparam logic [ADDR_W-1:0] ALL_ONES_ADDR    = '1;
   localparam logic [ADDR_W-1:0] OWN_ADDR_RESET   = '0;
   localparam logic [ADDR_W-1:0] OWN_BCAST_RESET  = '1;
   localparam logic [BYTE_W-1:0] PROTO_TCP        = 8'd6;
   localparam logic [BYTE_W-1:0] PROTO_UDP        = 8'd17;

   // fixed header byte offsets
   localparam logic [COUNT_W-1:0] POS_TOTAL_HI  = 16'd2;
   localparam logic [COUNT_W-1:0] POS_TOTAL_LO  = 16'd3;
   localparam logic [COUNT_W-1:0] POS_PROTOCOL  = 16'd9;
   localparam logic [COUNT_W-1:0] POS_SRC_FIRST = 16'd12;
   localparam logic [COUNT_W-1:0] POS_SRC_LAST  = 16'd15;
   localparam logic [COUNT_W-1:0] POS_DST_FIRST = 16'd16;
   localparam logic [COUNT_W-1:0] POS_DST_LAST  = 16'd19;

   typedef logic [STATUS_W-1:0] status_type;

   localparam status_type ST_TCP       = 3'd0;
   localparam status_type ST_UDP       = 3'd1;
   localparam status_type ST_OTHER     = 3'd2;
   localparam status_type ST_BAD_IHL   = 3'd3;
   localparam status_type ST_TRUNCATED = 3'd4;
   localparam status_type ST_NOT_OURS  = 3'd5;
   localparam status_type ST_BAD_SUM   = 3'd6;
   localparam status_type ST_TOTAL_LOW = 3'd7;

   localparam logic REG_OWN_ADDRESS   = 1'b0;
   localparam logic REG_OWN_BROADCAST = 1'b1;

   typedef struct packed {
      logic              advance;
      logic              last;
      logic [BYTE_W-1:0] data;
   } step_type;

   typedef struct packed {
      status_type         status;
      logic [BYTE_W-1:0]  protocol_number;
      logic [ADDR_W-1:0]  source_address;
      logic [ADDR_W-1:0]  destination_address;
      logic [IHL_W-1:0]   header_bytes;
      logic [COUNT_W-1:0] payload_length;
   } result_type;

endpackage

// ----- rtl/core/ipv4_header_checker.sv -----
// Top level of the IPv4 receive header checker: handshakes, config registers, result register.
//
//  channel  dir  handshake             payload
//  req      in   req_tvalid/tready     tdata = data_byte, tlast = last_byte
//  rsp      out  rsp_tvalid/tready     tdata = status..payload_length (97 bits, 0-padded)
//  csr      in   psel/penable/pwrite   own_address at 0x0, own_broadcast at 0x4
//
// One byte per cycle sustained unless a last byte waits on a stalled result: a byte
// is registered on accept and folded into the frame state as it leaves the input
// register; in that same cycle the verdict is computed into the result register, which drives rsp_tvalid.
// Synchronous reset clears frame state and sets own_broadcast to all ones.
// A stalled result only holds back the input register when it carries another last byte.
module ipv4_header_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [ipv4hc_pkg::BYTE_W-1:0]        req_tdata,   // [7:0] data_byte
   input  logic                                 req_tlast,   // last_byte
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [2:0] status, [10:3] protocol_number, [42:11] source_address,
   // [74:43] destination_address, [80:75] header_bytes, [96:81] payload_length
   output logic [ipv4hc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [ipv4hc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [ipv4hc_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [ipv4hc_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                 csr_pready
);
   import ipv4hc_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic              in_last_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_data_ff;
   logic [ADDR_W-1:0] own_addr_ff, own_bcast_ff;

   logic              req_accept;
   logic              in_advance;
   logic              rsp_load;
   logic              csr_write;
   step_type          step;
   result_type        verdict;

   assign req_accept = req_tvalid && req_tready;
   // only a last byte needs room in the result register
   assign in_advance = in_valid_ff && !(in_last_ff && rsp_valid_ff && !rsp_tready);
   assign req_tready = !in_valid_ff || in_advance;
   assign rsp_load   = in_advance && in_last_ff;

   assign step.advance = in_advance;
   assign step.last    = in_last_ff;
   assign step.data    = in_byte_ff;

   ipv4hc_frame u_frame (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .own_address   (own_addr_ff),
      .own_broadcast (own_bcast_ff),
      .result        (verdict)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (in_advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (rsp_load) begin
         rsp_data_ff <= verdict;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_data_ff.payload_length, rsp_data_ff.header_bytes,
                        rsp_data_ff.destination_address, rsp_data_ff.source_address,
                        rsp_data_ff.protocol_number, rsp_data_ff.status};

   // config registers; byte offset bits of paddr are ignored
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_addr_ff  <= OWN_ADDR_RESET;
         own_bcast_ff <= OWN_BCAST_RESET;
      end else if (csr_write) begin
         case (csr_paddr[2])
            REG_OWN_ADDRESS:   own_addr_ff  <= csr_pwdata;
            REG_OWN_BROADCAST: own_bcast_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_OWN_BROADCAST) ? own_bcast_ff : own_addr_ff;

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_advance && in_last_ff))
      else $error("result raised without a last byte");

   a_in_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !in_advance |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_last_ff))
      else $error("stalled input register changed");

   a_fail_no_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status != ST_TCP && rsp_data_ff.status != ST_UDP &&
      rsp_data_ff.status != ST_OTHER |-> rsp_data_ff.payload_length == '0)
      else $error("payload length on a rejected frame");

   a_pass_min_header: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.status == ST_TCP || rsp_data_ff.status == ST_UDP ||
      rsp_data_ff.status == ST_OTHER) |-> rsp_data_ff.header_bytes >= MIN_HEADER_BYTES)
      else $error("short header passed");

endmodule

// ----- rtl/core/ipv4hc_frame.sv -----
// Per-frame header capture, running checksum and verdict logic.
module ipv4hc_frame (
   input  logic                             clock,
   input  logic                             reset,
   input  ipv4hc_pkg::step_type             step,
   input  logic [ipv4hc_pkg::ADDR_W-1:0]    own_address,
   input  logic [ipv4hc_pkg::ADDR_W-1:0]    own_broadcast,
   output ipv4hc_pkg::result_type           result
);
   import ipv4hc_pkg::*;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [IHL_W-1:0]   ihl_ff, ihl_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [BYTE_W-1:0]  hold_ff, hold_in;
   logic [WORD_W-1:0]  total_ff, total_in;
   logic [BYTE_W-1:0]  proto_ff, proto_in;
   logic [ADDR_W-1:0]  src_ff, src_in;
   logic [ADDR_W-1:0]  dst_ff, dst_in;

   logic [SUM_W:0]     word_sum;
   logic [COUNT_W-1:0] hdr_wide;
   logic [COUNT_W-1:0] min_len;
   logic               dst_ok;
   logic               sum_bad;

   always_comb begin
      count_in = count_ff;
      ihl_in   = ihl_ff;
      sum_in   = sum_ff;
      hold_in  = hold_ff;
      total_in = total_ff;
      proto_in = proto_ff;
      src_in   = src_ff;
      dst_in   = dst_ff;
      word_sum = {1'b0, sum_ff} + {2'b00, hold_ff, step.data};

      if (count_ff == '0) begin
         ihl_in = IHL_W'(step.data[3:0]) << IHL_SHIFT;
      end
      hdr_wide = COUNT_W'(ihl_in);

      // only header bytes enter the checksum; byte 0 always does
      if (count_ff == '0 || count_ff < hdr_wide) begin
         if (!count_ff[0]) begin
            hold_in = step.data;
         end else begin
            sum_in = SUM_W'(word_sum[WORD_W-1:0]) + SUM_W'(word_sum[SUM_W:WORD_W]);
         end
      end

      case (count_ff) inside
         POS_TOTAL_HI:                  total_in = {step.data, total_ff[7:0]};
         POS_TOTAL_LO:                  total_in = {total_ff[15:8], step.data};
         POS_PROTOCOL:                  proto_in = step.data;
         [POS_SRC_FIRST:POS_SRC_LAST]:  src_in   = {src_ff[ADDR_W-BYTE_W-1:0], step.data};
         [POS_DST_FIRST:POS_DST_LAST]:  dst_in   = {dst_ff[ADDR_W-BYTE_W-1:0], step.data};
         default: ;
      endcase

      if (count_ff != '1) begin
         count_in = count_ff + COUNT_W'(1);
      end

      // verdict on the state as it stands after this byte
      dst_ok  = (dst_in == own_address) || (dst_in == ALL_ONES_ADDR) ||
                (dst_in == own_broadcast);
      sum_bad = (~sum_in[WORD_W-1:0]) != GOOD_CHECKSUM;
      min_len = (total_in < count_in) ? total_in : count_in;

      result.protocol_number     = proto_in;
      result.source_address      = src_in;
      result.destination_address = dst_in;
      result.header_bytes        = ihl_in;
      result.payload_length      = '0;

      if (ihl_in < MIN_HEADER_BYTES) begin
         result.status = ST_BAD_IHL;
      end else if (count_in < hdr_wide) begin
         result.status = ST_TRUNCATED;
      end else if (!dst_ok) begin
         result.status = ST_NOT_OURS;
      end else if (sum_bad) begin
         result.status = ST_BAD_SUM;
      end else if (total_in < hdr_wide) begin
         result.status = ST_TOTAL_LOW;
      end else begin
         result.payload_length = min_len - hdr_wide;
         if (proto_in == PROTO_TCP) begin
            result.status = ST_TCP;
         end else if (proto_in == PROTO_UDP) begin
            result.status = ST_UDP;
         end else begin
            result.status = ST_OTHER;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step.advance && step.last)) begin
         count_ff <= '0;
         ihl_ff   <= '0;
         sum_ff   <= '0;
         hold_ff  <= '0;
         total_ff <= '0;
         proto_ff <= '0;
         src_ff   <= '0;
         dst_ff   <= '0;
      end else if (step.advance) begin
         count_ff <= count_in;
         ihl_ff   <= ihl_in;
         sum_ff   <= sum_in;
         hold_ff  <= hold_in;
         total_ff <= total_in;
         proto_ff <= proto_in;
         src_ff   <= src_in;
         dst_ff   <= dst_in;
      end
   end

   // a finished frame leaves nothing behind
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      step.advance && step.last |=> count_ff == '0 && sum_ff == '0 && ihl_ff == '0)
      else $error("frame state not cleared after last byte");

   // the folded sum never carries past one bit beyond a word
   a_sum_folded: assert property (@(posedge clock) disable iff (reset)
      sum_ff[SUM_W-1] |-> sum_ff[WORD_W-1:0] == '0)
      else $error("checksum accumulator not folded");

   a_count_saturates: assert property (@(posedge clock) disable iff (reset)
      step.advance && !step.last && count_ff == '1 |=> count_ff == '1)
      else $error("byte count wrapped");

endmodule

// ----- sim/tb_ipv4_header_checker.sv -----
// Testbench for the IPv4 header checker: directed and random frames, each verdict checked.
`timescale 1ns / 1ps

module tb_ipv4_header_checker;
   import ipv4hc_pkg::*;

   localparam int STUCK_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_BYTES   = 140;
   localparam int PHASE_FRAMES  = 5;

   typedef struct {
      logic [BYTE_W-1:0] data;
      logic              last;
   } frame_byte_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata   = '0;   // [7:0] data_byte
   logic                  req_tlast   = 1'b0; // last_byte
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   // [2:0] status, [10:3] protocol_number, [42:11] source_address,
   // [74:43] destination_address, [80:75] header_bytes, [96:81] payload_length
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   ipv4_header_checker i_dut (.*);

   // register copies and per-frame header state
   logic [ADDR_W-1:0]  own_addr_cfg  = OWN_ADDR_RESET;
   logic [ADDR_W-1:0]  own_bcast_cfg = OWN_BCAST_RESET;
   logic [COUNT_W-1:0] frame_pos     = '0;
   logic [IHL_W-1:0]   hdr_len       = '0;
   logic [SUM_W-1:0]   hdr_sum       = '0;
   logic [BYTE_W-1:0]  word_hi       = '0;
   logic [WORD_W-1:0]  total_seen    = '0;
   logic [BYTE_W-1:0]  proto_seen    = '0;
   logic [ADDR_W-1:0]  src_seen      = '0;
   logic [ADDR_W-1:0]  dst_seen      = '0;

   frame_byte_type byte_backlog[$];
   result_type  expected_verdicts[$];
   int unsigned bytes_offered = 0;
   int unsigned bytes_taken   = 0;
   int unsigned send_gap      = 0;
   int unsigned stall_gap     = 0;
   int unsigned phase_bytes   = 0;
   int          stuck_cycles  = 0;
   bit          idle_enabled  = 1'b1;
   bit          failed        = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
         failed = 1'b1;
      end
   endfunction

   // Folds one byte into the frame state; returns 1 with the verdict on the last byte.
   function automatic bit absorb_byte(input logic [BYTE_W-1:0] b, input logic last,
                                      output result_type verdict);
      logic [17:0]        s;
      logic [COUNT_W-1:0] hdr16;
      logic [COUNT_W-1:0] seen;
      logic [WORD_W-1:0]  check;
      verdict = '0;
      if (frame_pos == '0) hdr_len = {b[3:0], 2'b00};
      hdr16 = COUNT_W'(hdr_len);
      // byte 0 always enters the sum, later bytes only inside the header
      if (frame_pos == '0 || frame_pos < hdr16) begin
         if (!frame_pos[0]) begin
            word_hi = b;
         end else begin
            s = 18'(hdr_sum) + 18'({word_hi, b});
            hdr_sum = 17'(s[15:0]) + 17'(s[17:16]);
         end
      end
      if (frame_pos == POS_TOTAL_HI) total_seen[15:8] = b;
      else if (frame_pos == POS_TOTAL_LO) total_seen[7:0] = b;
      else if (frame_pos == POS_PROTOCOL) proto_seen = b;
      else if (frame_pos >= POS_SRC_FIRST && frame_pos <= POS_SRC_LAST)
         src_seen = {src_seen[23:0], b};
      else if (frame_pos >= POS_DST_FIRST && frame_pos <= POS_DST_LAST)
         dst_seen = {dst_seen[23:0], b};
      if (frame_pos != '1) frame_pos++;
      if (!last) return 1'b0;

      seen  = frame_pos;
      check = ~hdr_sum[WORD_W-1:0];
      verdict.protocol_number     = proto_seen;
      verdict.source_address      = src_seen;
      verdict.destination_address = dst_seen;
      verdict.header_bytes        = hdr_len;
      if (hdr_len < MIN_HEADER_BYTES) verdict.status = ST_BAD_IHL;
      else if (seen < hdr16) verdict.status = ST_TRUNCATED;
      else if (dst_seen != own_addr_cfg && dst_seen != ALL_ONES_ADDR &&
               dst_seen != own_bcast_cfg) verdict.status = ST_NOT_OURS;
      else if (check != GOOD_CHECKSUM) verdict.status = ST_BAD_SUM;
      else if (total_seen < hdr16) verdict.status = ST_TOTAL_LOW;
      else begin
         verdict.payload_length = (total_seen < seen ? total_seen : seen) - hdr16;
         if (proto_seen == PROTO_TCP) verdict.status = ST_TCP;
         else if (proto_seen == PROTO_UDP) verdict.status = ST_UDP;
         else verdict.status = ST_OTHER;
      end

      frame_pos  = '0;
      hdr_len    = '0;
      hdr_sum    = '0;
      word_hi    = '0;
      total_seen = '0;
      proto_seen = '0;
      src_seen   = '0;
      dst_seen   = '0;
      return 1'b1;
   endfunction

   // Builds a frame with a correct header checksum unless told otherwise.
   // total < 0 puts the built length in the total length field; cut > 0 ends the frame early.
   task automatic queue_frame(input int ihl, input int pay_len, input int total,
                              input logic [BYTE_W-1:0] proto, input logic [ADDR_W-1:0] dst,
                              input bit bad_sum, input int cut, input logic [3:0] version);
      logic [BYTE_W-1:0] frame_bytes[$];
      logic [31:0]       acc;
      logic [WORD_W-1:0] cks;
      logic [WORD_W-1:0] tl;
      int                hdr;
      int                n;
      int                len;
      hdr = ihl * 4;
      n = (hdr > 20 ? hdr : 20) + pay_len;
      for (int i = 0; i < n; i++) frame_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
      tl = (total < 0) ? WORD_W'(n) : WORD_W'(total);
      frame_bytes[0] = {version, 4'(ihl)};
      frame_bytes[2] = tl[15:8];
      frame_bytes[3] = tl[7:0];
      frame_bytes[9] = proto;
      for (int i = 0; i < 4; i++) frame_bytes[16 + i] = dst[31 - 8 * i -: 8];
      frame_bytes[10] = '0;
      frame_bytes[11] = '0;
      acc = '0;
      for (int i = 0; i < hdr / 2; i++) acc += {frame_bytes[2 * i], frame_bytes[2 * i + 1]};
      while (acc[31:16] != '0) acc = acc[15:0] + acc[31:16];
      cks = ~acc[15:0];
      if (bad_sum) cks ^= WORD_W'(1) << $urandom_range(0, 15);
      frame_bytes[10] = cks[15:8];
      frame_bytes[11] = cks[7:0];
      len = (cut > 0 && cut < n) ? cut : n;
      for (int i = 0; i < len; i++)
         byte_backlog.push_back('{data: frame_bytes[i], last: (i == len - 1)});
      phase_bytes += len;
   endtask

   task automatic queue_random_frame();
      int                pick;
      int                ihl;
      int                pay;
      int                n;
      int                total;
      logic [ADDR_W-1:0] dst;
      logic [BYTE_W-1:0] proto;
      logic [3:0]        version;
      pick    = $urandom_range(0, 99);
      ihl     = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5;
      pay     = $urandom_range(0, 12);
      n       = ihl * 4 + pay;
      version = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd4;
      case ($urandom_range(0, 3))
         0: proto = PROTO_UDP;
         1: proto = BYTE_W'($urandom);
         default: proto = PROTO_TCP;
      endcase
      case ($urandom_range(0, 3))
         0: dst = own_bcast_cfg;
         1: dst = ALL_ONES_ADDR;
         default: dst = own_addr_cfg;
      endcase
      case ($urandom_range(0, 2))
         0: total = -1;
         1: total = $urandom_range(ihl * 4, n);     // link padding after the datagram
         default: total = $urandom_range(n, 65535);
      endcase
      if (pick < 60) queue_frame(ihl, pay, total, proto, dst, 1'b0, 0, version);
      else if (pick < 68) queue_frame(ihl, pay, total, proto, dst, 1'b1, 0, version);
      else if (pick < 76) queue_frame(ihl, pay, total, proto, $urandom, 1'b0, 0, version);
      else if (pick < 82)
         queue_frame($urandom_range(0, 4), pay, total, proto, dst, 1'b0, 0, version);
      else if (pick < 88)
         queue_frame(ihl, pay, total, proto, dst, 1'b0, $urandom_range(1, ihl * 4 - 1), version);
      else if (pick < 94)
         queue_frame(ihl, pay, $urandom_range(0, ihl * 4 - 1), proto, dst, 1'b0, 0, version);
      else
         queue_frame($urandom_range(0, 15), $urandom_range(0, 20), $urandom_range(0, 65535),
                     BYTE_W'($urandom), ADDR_W'($urandom), 1'($urandom_range(0, 1)),
                     $urandom_range(1, 40), 4'($urandom));
   endtask

   task automatic csr_cycle(input bit write, input logic reg_index,
                            input logic [CSR_DATA_W-1:0] value, input string name);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = write;
      csr_paddr   = CSR_ADDR_W'({reg_index, 2'b00});
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (!write) check_field(name, value, csr_prdata);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic set_reg(input logic reg_index, input logic [CSR_DATA_W-1:0] value);
      string name;
      name = (reg_index == REG_OWN_ADDRESS) ? "own_address" : "own_broadcast";
      csr_cycle(1'b1, reg_index, value, name);
      if (reg_index == REG_OWN_ADDRESS) own_addr_cfg = value;
      else own_bcast_cfg = value;
      csr_cycle(1'b0, reg_index, value, name);
   endtask

   // waits until every frame has been sent and judged, then lets the pipeline empty
   task automatic settle();
      while (byte_backlog.size() != 0 || req_tvalid || expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(negedge clock) begin : feed_bytes
      frame_byte_type next_byte;
      if (!(req_tvalid && bytes_taken != bytes_offered)) begin
         if (send_gap == 0 && idle_enabled && $urandom_range(0, 9) == 0)
            send_gap = $urandom_range(1, 13);
         if (send_gap > 0 || byte_backlog.size() == 0) begin
            if (send_gap > 0) send_gap--;
            req_tvalid <= 1'b0;
         end else begin
            next_byte = byte_backlog.pop_front();
            req_tdata  <= next_byte.data;
            req_tlast  <= next_byte.last;
            req_tvalid <= 1'b1;
            bytes_offered++;
         end
      end
   end

   always @(negedge clock) begin
      if (stall_gap == 0 && idle_enabled && $urandom_range(0, 5) == 0)
         stall_gap = $urandom_range(1, 13);
      if (stall_gap > 0) begin
         stall_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : watch_bus
      result_type predicted;
      result_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            bytes_taken++;
            if (absorb_byte(req_tdata, req_tlast, predicted))
               expected_verdicts.push_back(predicted);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_verdicts.size() == 0) begin
               $error("verdict arrived with no frame outstanding");
               failed = 1'b1;
            end else begin
               want = expected_verdicts.pop_front();
               check_field("status", want.status, rsp_tdata[2:0]);
               check_field("protocol_number", want.protocol_number, rsp_tdata[10:3]);
               check_field("source_address", want.source_address, rsp_tdata[42:11]);
               check_field("destination_address", want.destination_address, rsp_tdata[74:43]);
               check_field("header_bytes", want.header_bytes, rsp_tdata[80:75]);
               check_field("payload_length", want.payload_length, rsp_tdata[96:81]);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == STUCK_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      logic [ADDR_W-1:0] subnet;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed frames under the reset register values
      queue_frame(5, 4, -1, PROTO_TCP, ALL_ONES_ADDR, 1'b0, 0, 4'd4);
      queue_frame(15, 0, -1, PROTO_UDP, OWN_ADDR_RESET, 1'b0, 0, 4'd4);   // longest header
      queue_frame(5, 6, 65535, 8'hFF, ALL_ONES_ADDR, 1'b0, 0, 4'hF);      // total past frame end
      queue_frame(5, 3, 20, 8'h00, OWN_BCAST_RESET, 1'b0, 0, 4'h0);       // padded, no payload
      queue_frame(0, 2, -1, PROTO_TCP, ALL_ONES_ADDR, 1'b0, 0, 4'd4);     // zero IHL
      queue_frame(4, 2, -1, PROTO_TCP, ALL_ONES_ADDR, 1'b0, 0, 4'd4);
      queue_frame(5, 0, -1, PROTO_TCP, ALL_ONES_ADDR, 1'b0, 1, 4'd4);     // one-byte frame
      queue_frame(10, 8, -1, PROTO_UDP, ALL_ONES_ADDR, 1'b0, 30, 4'd4);   // ends inside options
      queue_frame(5, 0, -1, PROTO_UDP, ALL_ONES_ADDR, 1'b0, 15, 4'd4);    // ends before dest
      queue_frame(5, 2, -1, PROTO_TCP, 32'h1234_5678, 1'b0, 0, 4'd4);
      queue_frame(6, 2, -1, PROTO_UDP, ALL_ONES_ADDR, 1'b1, 0, 4'd4);
      queue_frame(5, 2, 19, PROTO_TCP, ALL_ONES_ADDR, 1'b0, 0, 4'd4);
      queue_frame(5, 2, 0, PROTO_TCP, ALL_ONES_ADDR, 1'b0, 0, 4'd4);
      settle();

      for (int ph = 1; ph <= 5; ph++) begin
         case (ph)
            1: begin
               set_reg(REG_OWN_ADDRESS, '0);
               set_reg(REG_OWN_BROADCAST, '0);
            end
            2: begin
               set_reg(REG_OWN_ADDRESS, '1);
               set_reg(REG_OWN_BROADCAST, '1);
            end
            3: begin
               set_reg(REG_OWN_ADDRESS, $urandom);
               set_reg(REG_OWN_BROADCAST, $urandom);
            end
            default: begin
               subnet = {8'd10, 8'($urandom), 8'($urandom), 8'd0};
               set_reg(REG_OWN_ADDRESS, subnet | ADDR_W'(1));
               set_reg(REG_OWN_BROADCAST, subnet | ADDR_W'(8'hFF));
            end
         endcase
         idle_enabled = (ph != 5);
         phase_bytes = 0;
         for (int f = 0; phase_bytes < PHASE_BYTES || f < PHASE_FRAMES; f++)
            queue_random_frame();
         settle();
      end

      if (!failed && expected_verdicts.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
